/* hw/rtl/mlg_pkg.sv */
`timescale 1ns / 1ps
package mlg_pkg;

	localparam int MAX_FEATURES = 16;
	localparam int MAX_SAMPLES  = 65536;
	localparam int DATA_WIDTH   = 16;

	localparam int IDX_W   = $clog2(MAX_FEATURES);
	localparam int NCNT_W  = $clog2(MAX_FEATURES + 1);
	localparam int CFG_W   = 7;
	localparam int ERR_W   = DATA_WIDTH + 1;
	localparam int PROD_W  = 2 * DATA_WIDTH + 2;
	localparam int GRAD_W  = 50;
	localparam int SQ_W    = 49;
	localparam int ESUM_W  = 34;
	localparam int CNT_W   = 17;
	localparam int BIAS_W  = 35;
	localparam int WIDX_W  = 6;
	localparam int STAT_W  = 2;
	localparam int DIVQ_W  = GRAD_W + 1;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_MIDROW   = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_LOSS_GO,
		S_LOSS_WAIT,
		S_BIAS_GO,
		S_BIAS_WAIT,
		S_RD,
		S_WG_GO,
		S_WG_WAIT
	} state_t;

	// Request to the shared divider.
	typedef struct packed {
		logic              go;
		logic [DIVQ_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

endpackage

/* hw/rtl/mlg_ram.sv */
`timescale 1ns / 1ps
module mlg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/mlg_divider.sv */
`timescale 1ns / 1ps
module mlg_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mlg_pkg::div_req_t         req,
	output logic                      done,
	output logic [mlg_pkg::DIVQ_W-1:0] quotient
);

	localparam int STEP_W = $clog2(mlg_pkg::DIVQ_W + 1);

	logic [mlg_pkg::DIVQ_W-1:0] dq_q;
	logic [mlg_pkg::CNT_W-1:0]  rem_q;
	logic [mlg_pkg::CNT_W-1:0]  div_q;
	logic [STEP_W-1:0]          step_q;
	logic                       run_q;
	logic                       done_q;
	logic [mlg_pkg::CNT_W:0]    trial;
	logic [mlg_pkg::CNT_W:0]    diff;
	logic                       fits;

	// One restoring step: bring down the next dividend bit and try the subtract.
	always_comb begin
		trial = {rem_q, dq_q[mlg_pkg::DIVQ_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	// Control of the iteration, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && !req.go && (step_q == STEP_W'(1));
			if (req.go) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(mlg_pkg::DIVQ_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Shared dividend and quotient register, remainder register.
	always_ff @(posedge clk) begin
		if (req.go) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (run_q) begin
			dq_q  <= {dq_q[mlg_pkg::DIVQ_W-2:0], fits};
			rem_q <= fits ? diff[mlg_pkg::CNT_W-1:0] : trial[mlg_pkg::CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

/* hw/rtl/mse_loss_and_gradient.sv */
`timescale 1ns / 1ps
// Mean squared error loss and gradient unit. Each item is one feature element of a
// sample row; an item is taken when start is high and busy is low, and each item
// holds busy while its feature accumulator is read, updated and written back in
// the accumulator memory, so the block takes no new item before that write-back.
// The item flagged batch_end then starts the result pass: the loss and the bias
// gradient are divided by the sample count first, and then each feature's
// accumulator is read and divided. Each division runs 51 steps on the shared
// bit-serial divider, and busy stays high for the whole result pass.
// Results come out one per feature, each on the ports for a single cycle with
// out_strobe high; the receiver cannot stall them and must take every one.
// Accumulators are cleared through per-entry valid bits, with no clearing pass.
module mse_loss_and_gradient (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mlg_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [mlg_pkg::DATA_WIDTH-1:0] target,
	input  logic signed [mlg_pkg::DATA_WIDTH-1:0] predicted,
	input  logic signed [mlg_pkg::DATA_WIDTH-1:0] x_value,
	input  logic                              batch_end,
	output logic                              out_strobe,
	output logic [mlg_pkg::WIDX_W-1:0]        weight_index,
	output logic signed [mlg_pkg::GRAD_W-1:0] weight_grad,
	output logic [mlg_pkg::SQ_W-1:0]          loss,
	output logic signed [mlg_pkg::BIAS_W-1:0] bias_grad,
	output logic [mlg_pkg::STAT_W-1:0]        status,
	output logic                              last
);

	localparam int NF = mlg_pkg::MAX_FEATURES;
	localparam int IW = mlg_pkg::IDX_W;
	localparam int NW = mlg_pkg::NCNT_W;

	mlg_pkg::state_t state_q, state_d;

	logic [mlg_pkg::CFG_W-1:0]      num_features_q;
	logic [NW-1:0]                  n_eff;
	logic [IW-1:0]                  feature_pos_q;
	logic [IW-1:0]                  pos_eff;
	logic [mlg_pkg::STAT_W-1:0]     fault_code_q;
	logic [mlg_pkg::CNT_W-1:0]      sample_count_q;
	logic [mlg_pkg::SQ_W-1:0]       sq_err_sum_q;
	logic signed [mlg_pkg::ESUM_W-1:0] err_sum_q;
	logic [NF-1:0]                  valid_q;
	logic                           accept;
	logic                           row_start;
	logic                           do_row;
	logic                           set_fault;

	logic signed [mlg_pkg::ERR_W-1:0]      err_s1;
	logic signed [mlg_pkg::DATA_WIDTH-1:0] x_s1;
	logic [IW-1:0]                  pos_s1;
	logic                           end_s1;
	logic                           acc_en_s1;
	logic                           row_s1;
	logic                           midrow_q;
	logic [mlg_pkg::STAT_W-1:0]     stat_q;

	logic [IW-1:0]                  k_q;
	logic                           bias_neg_q;
	logic                           wg_neg_q;
	logic [mlg_pkg::SQ_W-1:0]       loss_q;
	logic signed [mlg_pkg::BIAS_W-1:0] bias_q;

	logic                           ram_we;
	logic                           ram_re;
	logic [IW-1:0]                  ram_raddr;
	logic [mlg_pkg::GRAD_W-1:0]     ram_wdata;
	logic [mlg_pkg::GRAD_W-1:0]     ram_rdata;
	logic signed [mlg_pkg::GRAD_W-1:0] grad_old;

	logic signed [mlg_pkg::PROD_W-1:0] prod_ex;
	logic signed [mlg_pkg::PROD_W-1:0] prod_ee;

	logic signed [mlg_pkg::BIAS_W:0]   bias_v;
	logic [mlg_pkg::BIAS_W:0]          bias_mag;
	logic signed [mlg_pkg::DIVQ_W:0]   wg_v;
	logic [mlg_pkg::DIVQ_W:0]          wg_mag;
	logic [mlg_pkg::DIVQ_W:0]          q_signed;

	mlg_pkg::div_req_t              div_req;
	logic                           div_done;
	logic [mlg_pkg::DIVQ_W-1:0]     div_quot;
	logic                           m_zero;
	logic                           k_last;

	// Effective row length and position.
	always_comb begin
		if (num_features_q == '0) begin
			n_eff = NW'(1);
		end else if (num_features_q > mlg_pkg::CFG_W'(NF)) begin
			n_eff = NW'(NF);
		end else begin
			n_eff = num_features_q[NW-1:0];
		end
		pos_eff   = ({1'b0, feature_pos_q} >= n_eff) ? '0 : feature_pos_q;
		accept    = start && (state_q == mlg_pkg::S_IDLE);
		row_start = (fault_code_q != mlg_pkg::ST_OVERFLOW) && (pos_eff == '0);
		set_fault = row_start &&
			(sample_count_q >= mlg_pkg::CNT_W'(mlg_pkg::MAX_SAMPLES));
		do_row    = row_start && !set_fault;
		m_zero    = (sample_count_q == '0);
		k_last    = ({1'b0, k_q} == n_eff - 1'b1);
	end

	// Accumulator memory access.
	always_comb begin
		grad_old  = valid_q[pos_s1] ? ram_rdata : '0;
		prod_ex   = mlg_pkg::PROD_W'(err_s1) * mlg_pkg::PROD_W'(x_s1);
		prod_ee   = mlg_pkg::PROD_W'(err_s1) * mlg_pkg::PROD_W'(err_s1);
		ram_we    = (state_q == mlg_pkg::S_ACC) && acc_en_s1;
		ram_wdata = grad_old + mlg_pkg::GRAD_W'(prod_ex);
		ram_re    = accept || (state_q == mlg_pkg::S_RD);
		ram_raddr = (state_q == mlg_pkg::S_RD) ? k_q : pos_eff;
	end

	mlg_ram #(
		.WIDTH(mlg_pkg::GRAD_W),
		.DEPTH(NF)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_s1),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Signed dividends, taken apart into sign and magnitude.
	always_comb begin
		bias_v   = -((mlg_pkg::BIAS_W + 1)'(err_sum_q) <<< 1);
		bias_mag = bias_v[mlg_pkg::BIAS_W] ? (mlg_pkg::BIAS_W + 1)'(-bias_v)
			: (mlg_pkg::BIAS_W + 1)'(bias_v);
		wg_v     = -((mlg_pkg::DIVQ_W + 1)'(signed'(valid_q[k_q] ? ram_rdata : '0)) <<< 1);
		wg_mag   = wg_v[mlg_pkg::DIVQ_W] ? (mlg_pkg::DIVQ_W + 1)'(-wg_v)
			: (mlg_pkg::DIVQ_W + 1)'(wg_v);
		div_req.divisor = sample_count_q;
		div_req.go = (state_q == mlg_pkg::S_LOSS_GO) || (state_q == mlg_pkg::S_BIAS_GO) ||
			(state_q == mlg_pkg::S_WG_GO);
		case (state_q)
			mlg_pkg::S_LOSS_GO: div_req.dividend = mlg_pkg::DIVQ_W'(sq_err_sum_q);
			mlg_pkg::S_BIAS_GO: div_req.dividend = mlg_pkg::DIVQ_W'(bias_mag);
			default:            div_req.dividend = wg_mag[mlg_pkg::DIVQ_W-1:0];
		endcase
	end

	mlg_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done    (div_done),
		.quotient(div_quot)
	);

	// Quotient with the sign of the current division.
	always_comb begin
		q_signed = {1'b0, div_quot};
		if ((state_q == mlg_pkg::S_BIAS_WAIT) ? bias_neg_q : wg_neg_q) begin
			q_signed = -{1'b0, div_quot};
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mlg_pkg::S_IDLE:      if (accept) state_d = mlg_pkg::S_ACC;
			mlg_pkg::S_ACC:       state_d = end_s1 ? mlg_pkg::S_LOSS_GO : mlg_pkg::S_IDLE;
			mlg_pkg::S_LOSS_GO:   state_d = mlg_pkg::S_LOSS_WAIT;
			mlg_pkg::S_LOSS_WAIT: if (div_done) state_d = mlg_pkg::S_BIAS_GO;
			mlg_pkg::S_BIAS_GO:   state_d = mlg_pkg::S_BIAS_WAIT;
			mlg_pkg::S_BIAS_WAIT: if (div_done) state_d = mlg_pkg::S_RD;
			mlg_pkg::S_RD:        state_d = mlg_pkg::S_WG_GO;
			mlg_pkg::S_WG_GO:     state_d = mlg_pkg::S_WG_WAIT;
			mlg_pkg::S_WG_WAIT: begin
				if (div_done) state_d = k_last ? mlg_pkg::S_IDLE : mlg_pkg::S_RD;
			end
			default:              state_d = mlg_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Batch state and result control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_features_q <= mlg_pkg::CFG_W'(1);
			feature_pos_q  <= '0;
			fault_code_q   <= mlg_pkg::ST_OK;
			sample_count_q <= '0;
			sq_err_sum_q   <= '0;
			err_sum_q      <= '0;
			valid_q        <= '0;
			k_q            <= '0;
			out_strobe     <= 1'b0;
		end else begin
			out_strobe <= (state_q == mlg_pkg::S_WG_WAIT) && div_done;
			if (cfg_we) begin
				num_features_q <= cfg_data;
			end
			if (accept) begin
				feature_pos_q <= ({1'b0, pos_eff} + 1'b1 >= n_eff) ? '0 : pos_eff + 1'b1;
				if (set_fault) begin
					fault_code_q <= mlg_pkg::ST_OVERFLOW;
				end
				if (do_row) begin
					sample_count_q <= sample_count_q + 1'b1;
				end
			end
			if (state_q == mlg_pkg::S_ACC) begin
				if (acc_en_s1) begin
					valid_q[pos_s1] <= 1'b1;
				end
				if (row_s1) begin
					sq_err_sum_q <= sq_err_sum_q + mlg_pkg::SQ_W'(prod_ee);
					err_sum_q    <= err_sum_q + mlg_pkg::ESUM_W'(err_s1);
				end
				k_q <= '0;
			end
			if ((state_q == mlg_pkg::S_WG_WAIT) && div_done) begin
				k_q <= k_q + 1'b1;
				if (k_last) begin
					feature_pos_q  <= '0;
					fault_code_q   <= mlg_pkg::ST_OK;
					sample_count_q <= '0;
					sq_err_sum_q   <= '0;
					err_sum_q      <= '0;
					valid_q        <= '0;
				end
			end
		end
	end

	// Item and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1    <= mlg_pkg::ERR_W'(target) - mlg_pkg::ERR_W'(predicted);
			x_s1      <= x_value;
			pos_s1    <= pos_eff;
			end_s1    <= batch_end;
			row_s1    <= do_row;
			acc_en_s1 <= (fault_code_q != mlg_pkg::ST_OVERFLOW) && !set_fault;
			midrow_q  <= ({1'b0, pos_eff} != n_eff - 1'b1);
		end
		if (state_q == mlg_pkg::S_ACC) begin
			stat_q <= (fault_code_q == mlg_pkg::ST_OVERFLOW) ? mlg_pkg::ST_OVERFLOW
				: (midrow_q ? mlg_pkg::ST_MIDROW : mlg_pkg::ST_OK);
		end
		if ((state_q == mlg_pkg::S_LOSS_WAIT) && div_done) begin
			loss_q <= m_zero ? '0 : div_quot[mlg_pkg::SQ_W-1:0];
		end
		if (state_q == mlg_pkg::S_BIAS_GO) begin
			bias_neg_q <= bias_v[mlg_pkg::BIAS_W];
		end
		if ((state_q == mlg_pkg::S_BIAS_WAIT) && div_done) begin
			bias_q <= m_zero ? '0 : q_signed[mlg_pkg::BIAS_W-1:0];
		end
		if (state_q == mlg_pkg::S_WG_GO) begin
			wg_neg_q <= wg_v[mlg_pkg::DIVQ_W];
		end
		if ((state_q == mlg_pkg::S_WG_WAIT) && div_done) begin
			weight_index <= mlg_pkg::WIDX_W'(k_q);
			weight_grad  <= m_zero ? '0 : q_signed[mlg_pkg::GRAD_W-1:0];
			loss         <= loss_q;
			bias_grad    <= bias_q;
			status       <= stat_q;
			last         <= k_last;
		end
	end

	assign busy = (state_q != mlg_pkg::S_IDLE);

endmodule

/* hw/rtl/mlg_checker.sv */
`timescale 1ns / 1ps
module mlg_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       out_strobe,
	input logic                       last,
	input logic [mlg_pkg::STAT_W-1:0] status
);

	// An accepted item always occupies the block for the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	// A result is only produced by a pass that was already running.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |-> $past(busy)) else $error("result without a running pass");

	// More results follow a result that is not the last one.
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe && !last |=> busy) else $error("result pass stopped early");

	// The last result ends the pass.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe && last |-> !busy) else $error("block busy after last result");

	// Status never carries the unused code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |-> (status == mlg_pkg::ST_OK || status == mlg_pkg::ST_MIDROW ||
			status == mlg_pkg::ST_OVERFLOW)) else $error("bad status code");

endmodule

bind mse_loss_and_gradient mlg_checker u_mlg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.out_strobe(out_strobe),
	.last      (last),
	.status    (status)
);
